// ===== hw/rtl/dll_pkg.sv =====
// ----------------------------------------------------------------------------
// dll_pkg
// Shared types and codes for the linked list manager: payload structs,
// operation codes, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package dll_pkg;

	typedef enum logic [4:0] {
		OP_CLEAR      = 5'd0,
		OP_INS_FIRST  = 5'd1,
		OP_INS_LAST   = 5'd2,
		OP_SEL_FIRST  = 5'd3,
		OP_SEL_LAST   = 5'd4,
		OP_RD_FIRST   = 5'd5,
		OP_RD_LAST    = 5'd6,
		OP_DEL_FIRST  = 5'd7,
		OP_DEL_LAST   = 5'd8,
		OP_DEL_AFTER  = 5'd9,
		OP_DEL_BEFORE = 5'd10,
		OP_INS_AFTER  = 5'd11,
		OP_INS_BEFORE = 5'd12,
		OP_RD_ACTIVE  = 5'd13,
		OP_WR_ACTIVE  = 5'd14,
		OP_NEXT       = 5'd15,
		OP_PREV       = 5'd16
	} op_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [4:0]         operation;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
		logic               cursor_valid;
		logic [4:0]         element_count;
	} res_t;

	// controller strobes to the datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic move;
		logic rdata;
		logic dtgt;
		logic dlink;
		logic dw1;
		logic dw2;
		logic icur;
		logic ifree;
		logic iw1;
		logic iw2;
		logic load;
	} ctl_t;

	// datapath flags back to the controller
	typedef struct packed {
		logic [4:0] op;
		logic       head_ok;
		logic       tail_ok;
		logic       cur_ok;
		logic       cur_is_head;
		logic       cur_is_tail;
		logic       full;
		logic       res_busy;
	} flg_t;

endpackage

// ===== hw/rtl/dll_ram.sv =====
// ----------------------------------------------------------------------------
// dll_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/dll_ctrl.sv =====
// ----------------------------------------------------------------------------
// dll_ctrl
// Sequencer for the list operations: walks each operation through its
// link reads and writes and hands the result to the output register.
// ----------------------------------------------------------------------------
module dll_ctrl
	import dll_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  flg_t flg,
	output ctl_t ctl
);

	typedef enum logic [12:0] {
		S_IDLE  = 13'h0001,
		S_EXEC  = 13'h0002,
		S_MOVE  = 13'h0004,
		S_RDATA = 13'h0008,
		S_DTGT  = 13'h0010,
		S_DLINK = 13'h0020,
		S_DW1   = 13'h0040,
		S_DW2   = 13'h0080,
		S_ICUR  = 13'h0100,
		S_IFREE = 13'h0200,
		S_IW1   = 13'h0400,
		S_IW2   = 13'h0800,
		S_DONE  = 13'h1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (cmd_valid) state_d = S_EXEC;
			S_EXEC: begin
				case (flg.op)
					OP_RD_FIRST:  state_d = flg.head_ok ? S_RDATA : S_DONE;
					OP_RD_LAST:   state_d = flg.tail_ok ? S_RDATA : S_DONE;
					OP_RD_ACTIVE: state_d = flg.cur_ok ? S_RDATA : S_DONE;
					OP_DEL_FIRST: state_d = flg.head_ok ? S_DLINK : S_DONE;
					OP_DEL_LAST:  state_d = flg.tail_ok ? S_DLINK : S_DONE;
					OP_DEL_AFTER:
						state_d = (flg.cur_ok && !flg.cur_is_tail) ? S_DTGT : S_DONE;
					OP_DEL_BEFORE:
						state_d = (flg.cur_ok && !flg.cur_is_head) ? S_DTGT : S_DONE;
					OP_NEXT, OP_PREV: state_d = flg.cur_ok ? S_MOVE : S_DONE;
					OP_INS_FIRST, OP_INS_LAST: state_d = flg.full ? S_DONE : S_IFREE;
					OP_INS_AFTER, OP_INS_BEFORE:
						state_d = (flg.cur_ok && !flg.full) ? S_ICUR : S_DONE;
					default: state_d = S_DONE;
				endcase
			end
			S_MOVE:  state_d = S_DONE;
			S_RDATA: state_d = S_DONE;
			S_DTGT:  state_d = S_DLINK;
			S_DLINK: state_d = S_DW1;
			S_DW1:   state_d = S_DW2;
			S_DW2:   state_d = S_DONE;
			S_ICUR:  state_d = S_IFREE;
			S_IFREE: state_d = S_IW1;
			S_IW1:   state_d = S_IW2;
			S_IW2:   state_d = S_DONE;
			S_DONE:  if (!flg.res_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign cmd_stall = (state_q != S_IDLE);

	always_comb begin
		ctl        = '0;
		ctl.accept = (state_q == S_IDLE) && cmd_valid;
		ctl.exec   = (state_q == S_EXEC);
		ctl.move   = (state_q == S_MOVE);
		ctl.rdata  = (state_q == S_RDATA);
		ctl.dtgt   = (state_q == S_DTGT);
		ctl.dlink  = (state_q == S_DLINK);
		ctl.dw1    = (state_q == S_DW1);
		ctl.dw2    = (state_q == S_DW2);
		ctl.icur   = (state_q == S_ICUR);
		ctl.ifree  = (state_q == S_IFREE);
		ctl.iw1    = (state_q == S_IW1);
		ctl.iw2    = (state_q == S_IW2);
		ctl.load   = (state_q == S_DONE) && !flg.res_busy;
	end

endmodule

// ===== hw/rtl/dll_dp.sv =====
// ----------------------------------------------------------------------------
// dll_dp
// List datapath: node data and link memories, list pointers, free list,
// fill mark and the result register.
// ----------------------------------------------------------------------------
module dll_dp
	import dll_pkg::*;
#(
	parameter int POOL_DEPTH = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  ctl_t ctl,
	output flg_t flg,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int IW = $clog2(POOL_DEPTH + 1);
	localparam int AW = $clog2(POOL_DEPTH);
	localparam logic [IW-1:0] NIL = IW'(POOL_DEPTH);

	logic [4:0]                  op_q;
	logic signed [DATA_WIDTH-1:0] val_q;
	logic [IW-1:0] head_q, tail_q, cur_q, free_q, cnt_q, fill_q;
	logic [IW-1:0] k_q, p_q, n_q, fnext_q;
	logic signed [31:0] rdv_q;
	logic [1:0]         st_q;
	logic               res_valid_q;
	res_t               res_q;

	logic [AW-1:0] nx_raddr, pv_raddr, dt_raddr, nx_waddr, pv_waddr, dt_waddr;
	logic [IW-1:0] nx_rd, pv_rd, nx_wdata, pv_wdata, tgt;
	logic [IW-1:0] nx_rsel, pv_rsel, dt_rsel, nx_wsel, pv_wsel, dt_wsel;
	logic          nx_we, pv_we, dt_we;
	logic signed [DATA_WIDTH-1:0] dt_rd;

	logic head_ok, tail_ok, cur_ok, full;

	assign head_ok = (head_q != NIL);
	assign tail_ok = (tail_q != NIL);
	assign cur_ok  = (cur_q != NIL);
	assign full    = (free_q == NIL);

	assign tgt = (op_q == OP_DEL_AFTER) ? nx_rd : pv_rd;

	// read address selection
	always_comb begin
		nx_rsel = cur_q;
		pv_rsel = cur_q;
		dt_rsel = cur_q;
		if (ctl.exec) begin
			case (op_q)
				OP_DEL_FIRST: begin
					nx_rsel = head_q;
					pv_rsel = head_q;
				end
				OP_DEL_LAST: begin
					nx_rsel = tail_q;
					pv_rsel = tail_q;
				end
				OP_INS_FIRST, OP_INS_LAST: nx_rsel = free_q;
				OP_RD_FIRST: dt_rsel = head_q;
				OP_RD_LAST:  dt_rsel = tail_q;
				default: ;
			endcase
		end else if (ctl.dtgt) begin
			nx_rsel = tgt;
			pv_rsel = tgt;
		end else if (ctl.icur) begin
			nx_rsel = free_q;
		end
	end

	// write port selection
	always_comb begin
		nx_we    = 1'b0;
		nx_wsel  = k_q;
		nx_wdata = n_q;
		pv_we    = 1'b0;
		pv_wsel  = k_q;
		pv_wdata = p_q;
		dt_we    = 1'b0;
		dt_wsel  = k_q;
		if (ctl.dw1) begin
			nx_we    = (p_q != NIL);
			nx_wsel  = p_q;
			pv_we    = (n_q != NIL);
			pv_wsel  = n_q;
		end else if (ctl.dw2) begin
			nx_we    = 1'b1;
			nx_wdata = free_q;
		end else if (ctl.iw1) begin
			nx_we = 1'b1;
			pv_we = 1'b1;
			dt_we = 1'b1;
		end else if (ctl.iw2) begin
			nx_we    = (p_q != NIL);
			nx_wsel  = p_q;
			nx_wdata = k_q;
			pv_we    = (n_q != NIL);
			pv_wsel  = n_q;
			pv_wdata = k_q;
		end else if (ctl.exec && op_q == OP_WR_ACTIVE) begin
			dt_we   = cur_ok;
			dt_wsel = cur_q;
		end
	end

	assign nx_raddr = nx_rsel[AW-1:0];
	assign pv_raddr = pv_rsel[AW-1:0];
	assign dt_raddr = dt_rsel[AW-1:0];
	assign nx_waddr = nx_wsel[AW-1:0];
	assign pv_waddr = pv_wsel[AW-1:0];
	assign dt_waddr = dt_wsel[AW-1:0];

	dll_ram #(.WIDTH(IW), .DEPTH(POOL_DEPTH)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.raddr(nx_raddr), .rdata(nx_rd)
	);

	dll_ram #(.WIDTH(IW), .DEPTH(POOL_DEPTH)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
		.raddr(pv_raddr), .rdata(pv_rd)
	);

	dll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(POOL_DEPTH)) u_data (
		.clk(clk), .we(dt_we), .waddr(dt_waddr), .wdata(val_q),
		.raddr(dt_raddr), .rdata(dt_rd)
	);

	// list pointers; nodes at or above the fill mark were never linked
	// and chain to their successor in the free list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NIL;
			tail_q <= NIL;
			cur_q  <= NIL;
			free_q <= '0;
			cnt_q  <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.exec) begin
				case (op_q)
					OP_CLEAR: begin
						head_q <= NIL;
						tail_q <= NIL;
						cur_q  <= NIL;
						free_q <= '0;
						cnt_q  <= '0;
						fill_q <= '0;
					end
					OP_SEL_FIRST: cur_q <= head_q;
					OP_SEL_LAST:  cur_q <= tail_q;
					default: ;
				endcase
			end
			if (ctl.move) begin
				cur_q <= (op_q == OP_NEXT) ? nx_rd : pv_rd;
			end
			if (ctl.dw1) begin
				if (p_q == NIL) head_q <= n_q;
				if (n_q == NIL) tail_q <= p_q;
			end
			if (ctl.dw2) begin
				free_q <= k_q;
				cnt_q  <= cnt_q - 1'b1;
				if (cur_q == k_q) cur_q <= NIL;
			end
			if (ctl.iw2) begin
				if (p_q == NIL) head_q <= k_q;
				if (n_q == NIL) tail_q <= k_q;
				free_q <= fnext_q;
				cnt_q  <= cnt_q + 1'b1;
				if (k_q == fill_q) fill_q <= fill_q + 1'b1;
			end
		end
	end

	// operation working registers
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			op_q  <= cmd.operation;
			val_q <= DATA_WIDTH'(cmd.value);
			st_q  <= ST_OK;
			rdv_q <= '0;
		end
		if (ctl.exec) begin
			case (op_q)
				OP_RD_FIRST:  if (!head_ok) st_q <= ST_EMPTY;
				OP_RD_LAST:   if (!tail_ok) st_q <= ST_EMPTY;
				OP_RD_ACTIVE: if (!cur_ok) st_q <= ST_EMPTY;
				OP_DEL_FIRST: k_q <= head_q;
				OP_DEL_LAST:  k_q <= tail_q;
				OP_INS_FIRST: begin
					if (full) st_q <= ST_FULL;
					k_q <= free_q;
					p_q <= NIL;
					n_q <= head_q;
				end
				OP_INS_LAST: begin
					if (full) st_q <= ST_FULL;
					k_q <= free_q;
					p_q <= tail_q;
					n_q <= NIL;
				end
				OP_INS_AFTER: begin
					if (cur_ok && full) st_q <= ST_FULL;
					k_q <= free_q;
					p_q <= cur_q;
				end
				OP_INS_BEFORE: begin
					if (cur_ok && full) st_q <= ST_FULL;
					k_q <= free_q;
					n_q <= cur_q;
				end
				default: ;
			endcase
		end
		if (ctl.rdata) begin
			rdv_q <= 32'(dt_rd);
		end
		if (ctl.dtgt) begin
			k_q <= tgt;
		end
		if (ctl.dlink) begin
			p_q <= pv_rd;
			n_q <= nx_rd;
		end
		if (ctl.icur) begin
			if (op_q == OP_INS_AFTER) n_q <= nx_rd;
			else p_q <= pv_rd;
		end
		if (ctl.ifree) begin
			fnext_q <= (free_q == fill_q) ? free_q + 1'b1 : nx_rd;
		end
		if (ctl.load) begin
			res_q.read_value    <= rdv_q;
			res_q.status        <= st_q;
			res_q.cursor_valid  <= cur_ok;
			res_q.element_count <= 5'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		flg             = '0;
		flg.op          = op_q;
		flg.head_ok     = head_ok;
		flg.tail_ok     = tail_ok;
		flg.cur_ok      = cur_ok;
		flg.cur_is_head = (cur_q == head_q);
		flg.cur_is_tail = (cur_q == tail_q);
		flg.full        = full;
		flg.res_busy    = res_valid_q && res_stall;
	end

endmodule

// ===== hw/rtl/doubly_linked_list_with_cursor.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_with_cursor
// Doubly linked list with cursor over a bounded node pool and free list.
// Each operation steps through its dependent link memory reads and writes;
// delete after/before first reads the target node, and insert at cursor
// first reads the neighbour of the cursor.
// Throughput: one operation at a time; the next is taken once the result
// is in the output register. Reset and clear need no clearing pass: a fill
// mark stands in for the reset chaining of the free list.
// ----------------------------------------------------------------------------
module doubly_linked_list_with_cursor
	import dll_pkg::*;
#(
	parameter int POOL_DEPTH = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	ctl_t ctl;
	flg_t flg;

	dll_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall), .flg(flg), .ctl(ctl)
	);

	dll_dp #(.POOL_DEPTH(POOL_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .ctl(ctl), .flg(flg),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

endmodule
